@@ rtl/core/mesi_pkg.sv @@
package mesi_pkg;

    localparam int NumProc  = 4;
    localparam int ProcW    = 2;
    localparam int NumLines = 256;
    localparam int LineAw   = $clog2(NumLines);
    localparam int WordW    = 2 * NumProc;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_PEER = 2'd2;

    localparam logic [1:0] MODE_RD   = 2'd0;
    localparam logic [1:0] MODE_RDX  = 2'd1;
    localparam logic [1:0] MODE_UPG  = 2'd2;
    localparam logic [1:0] MODE_WB   = 2'd3;

    typedef struct packed {
        logic             found;
        logic             stop;
        logic             wb;
        logic [ProcW-1:0] wb_owner;
        logic [ProcW-1:0] supplier;
        logic [1:0]       inv;
    } scan_t;

endpackage

@@ rtl/core/mesi_ram.sv @@
module mesi_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mesi_step.sv @@
module mesi_step
    import mesi_pkg::*;
(
    input  logic [1:0]       mode,
    input  logic [ProcW-1:0] requestor,
    input  logic [ProcW-1:0] proc,
    input  logic [WordW-1:0] word_in,
    input  scan_t            scan_in,
    output logic [WordW-1:0] word_out,
    output scan_t            scan_out
);

    logic [1:0]       st;
    logic [1:0]       inv_inc;
    logic [ProcW:0]   base;

    assign base    = {proc, 1'b0};
    assign st      = word_in[base +: 2];
    assign inv_inc = (scan_in.inv == 2'd3) ? scan_in.inv : scan_in.inv + 2'd1;

    always_comb
    begin
        word_out = word_in;
        scan_out = scan_in;
        if (proc != requestor && !scan_in.stop)
        begin
            case (mode)
                MODE_RD:
                begin
                    if (st != ST_I)
                    begin
                        if (st == ST_M)
                        begin
                            scan_out.wb       = 1'b1;
                            scan_out.wb_owner = proc;
                        end
                        word_out[base +: 2] = ST_S;
                        scan_out.supplier   = proc;
                        scan_out.found      = 1'b1;
                        scan_out.stop       = 1'b1;
                    end
                end
                MODE_RDX:
                begin
                    if (st == ST_M)
                    begin
                        scan_out.wb         = 1'b1;
                        scan_out.wb_owner   = proc;
                        scan_out.supplier   = proc;
                        scan_out.found      = 1'b1;
                        scan_out.stop       = 1'b1;
                        scan_out.inv        = inv_inc;
                        word_out[base +: 2] = ST_I;
                    end
                    else if (st == ST_E || st == ST_S)
                    begin
                        if (!scan_in.found)
                        begin
                            scan_out.supplier = proc;
                            scan_out.found    = 1'b1;
                        end
                        scan_out.inv        = inv_inc;
                        word_out[base +: 2] = ST_I;
                    end
                end
                MODE_UPG:
                begin
                    if (st == ST_S)
                    begin
                        scan_out.inv        = inv_inc;
                        word_out[base +: 2] = ST_I;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/mesi_snoop_bus_controller_unit.sv @@
// Snooping-bus MESI controller. Each transaction reads the state word of one line, then a
// single per-processor update unit visits the processors one per cycle, and the new word is
// written back while the result is loaded into the output register. A transaction passes
// from acceptance through the registered line-table read, the scan of each processor in
// turn, and a step that writes the line and posts the result, then returns to idle before
// the next acceptance. A finished result may wait in the output register while the next
// transaction is accepted, but a transaction cannot finish until the previous result has
// been taken. Per-line valid bits make every line read as all Invalid after reset.
module mesi_snoop_bus_controller_unit
    import mesi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             txn_valid,
    output logic             txn_stall,
    input  logic [1:0]       mode,
    input  logic [7:0]       line_addr,
    input  logic [1:0]       requestor,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [1:0]       requestor_state,
    output logic [1:0]       data_source,
    output logic [1:0]       supplier,
    output logic             writeback,
    output logic [1:0]       writeback_owner,
    output logic [1:0]       invalidations
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ProcW-1:0]  proc_reg, proc_next;
    logic [1:0]        mode_reg;
    logic [LineAw-1:0] addr_reg;
    logic [ProcW-1:0]  req_reg;
    logic [WordW-1:0]  word_reg, word_next;
    scan_t             scan_reg, scan_next;
    logic              vld_reg [NumLines];
    logic              vld_rd_reg;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        rstate_reg, rstate_next;
    logic [1:0]        src_reg, src_next;
    logic [1:0]        sup_reg, sup_next;
    logic              wb_reg, wb_next;
    logic [1:0]        wbo_reg, wbo_next;
    logic [1:0]        inv_reg, inv_next;

    logic              txn_acc;
    logic              out_free;
    logic              commit;
    logic              req_ok;
    logic [WordW-1:0]  rdata;
    logic [WordW-1:0]  step_word;
    scan_t             step_scan;
    logic [WordW-1:0]  final_word;
    logic [1:0]        req_st;
    logic [ProcW:0]    req_base;

    assign txn_stall = (state_reg != S_IDLE);
    assign txn_acc   = txn_valid && !txn_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign commit    = (state_reg == S_DONE) && out_free;
    assign req_ok    = int'(req_reg) < NumProc;
    assign req_base  = {req_reg, 1'b0};
    assign req_st    = word_reg[req_base +: 2];

    mesi_ram #(
        .Width (WordW),
        .Depth (NumLines)
    ) u_line_ram (
        .clk   (clk),
        .we    (commit && req_ok),
        .waddr (addr_reg),
        .wdata (final_word),
        .re    (txn_acc),
        .raddr (line_addr[LineAw-1:0]),
        .rdata (rdata)
    );

    mesi_step u_step (
        .mode      (mode_reg),
        .requestor (req_reg),
        .proc      (proc_reg),
        .word_in   (word_reg),
        .scan_in   (scan_reg),
        .word_out  (step_word),
        .scan_out  (step_scan)
    );

    always_comb
    begin
        final_word           = word_reg;
        final_word[req_base +: 2] = rstate_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        proc_next      = proc_reg;
        word_next      = word_reg;
        scan_next      = scan_reg;
        res_valid_next = res_valid_reg;
        rstate_next    = ST_I;
        src_next       = SRC_NONE;
        sup_next       = scan_reg.supplier;
        wb_next        = scan_reg.wb;
        wbo_next       = scan_reg.wb_owner;
        inv_next       = scan_reg.inv;

        case (mode_reg)
            MODE_RD:
            begin
                rstate_next = scan_reg.found ? ST_S : ST_E;
                src_next    = scan_reg.found ? SRC_PEER : SRC_MEM;
            end
            MODE_RDX:
            begin
                rstate_next = ST_M;
                src_next    = scan_reg.found ? SRC_PEER : SRC_MEM;
            end
            MODE_UPG:
            begin
                rstate_next = ST_M;
            end
            default:
            begin
                rstate_next = ST_I;
                wb_next     = (req_st == ST_M);
                wbo_next    = (req_st == ST_M) ? req_reg : '0;
            end
        endcase
        if (!req_ok)
        begin
            rstate_next = ST_I;
            src_next    = SRC_NONE;
            sup_next    = '0;
            wb_next     = 1'b0;
            wbo_next    = '0;
            inv_next    = '0;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (txn_acc)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                word_next  = vld_rd_reg ? rdata : '0;
                scan_next  = '0;
                proc_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                word_next = step_word;
                scan_next = step_scan;
                proc_next = proc_reg + 1'b1;
                if (proc_reg == ProcW'(NumProc - 1))
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NumLines; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (commit && req_ok)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg <= proc_next;
        word_reg <= word_next;
        scan_reg <= scan_next;
        if (txn_acc)
        begin
            mode_reg   <= mode;
            addr_reg   <= line_addr[LineAw-1:0];
            req_reg    <= requestor;
            vld_rd_reg <= vld_reg[line_addr[LineAw-1:0]];
        end
        if (commit)
        begin
            rstate_reg <= rstate_next;
            src_reg    <= src_next;
            sup_reg    <= sup_next;
            wb_reg     <= wb_next;
            wbo_reg    <= wbo_next;
            inv_reg    <= inv_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign requestor_state = rstate_reg;
    assign data_source     = src_reg;
    assign supplier        = (src_reg == SRC_PEER) ? sup_reg : 2'd0;
    assign writeback       = wb_reg;
    assign writeback_owner = wb_reg ? wbo_reg : 2'd0;
    assign invalidations   = inv_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid && !txn_stall |=> state_reg == S_LOAD)
        else $error("accepted transaction did not start a table read");

    a_stop_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && scan_reg.stop |-> scan_reg.found)
        else $error("scan stopped without a supplier");

    a_upgrade_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        commit && mode_reg == MODE_UPG |-> src_next == SRC_NONE && !wb_next)
        else $error("upgrade moved data or wrote back");

endmodule
